/* rtl/cds_pkg.sv */
// Package for the calendar date stepper: field widths, operation codes,
// sequencer states and the calendar tables.
// No dependencies; imported by calendar_date_stepper_top.
package cds_pkg;

   localparam int OP_W    = 2;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 10;
   localparam int DOY_W   = 9;
   localparam int WDAY_W  = 3;

   // Quotient register wide enough for the weekday sum, remainder register for year % 100.
   localparam int DIV_W     = 16;
   localparam int REM_W     = 8;
   localparam int YY_W      = YEAR_W + 1;
   localparam int CENT_W    = 8;
   localparam int ZT_W      = 6;

   // Reciprocals for year / 100 and sum / 7. Both are exact for dividends below 43690,
   // well above the largest year and the largest weekday sum.
   localparam int CENT_RECIP_W = 13;
   localparam int CENT_SHIFT   = 19;
   localparam int CENT_PROD_W  = YEAR_W + CENT_RECIP_W;
   localparam int WEEK_SHIFT   = 18;
   localparam int WEEK_PROD_W  = 2 * DIV_W;

   localparam logic [CENT_RECIP_W-1:0] CENT_RECIP = 13'd5243;
   localparam logic [DIV_W-1:0]        WEEK_RECIP = 16'd37450;

   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
   localparam logic [OP_W-1:0] OP_BACK    = 2'd2;

   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
   localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTHS    = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

   localparam logic [REM_W-1:0] DIVISOR_CENTURY = 8'd100;
   localparam logic [REM_W-1:0] DIVISOR_WEEK    = 8'd7;
   localparam logic [YY_W-1:0]  WEEK_YEAR_BIAS  = 15'd400;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_YLOAD,
      ST_YDIV,
      ST_STEP,
      ST_WLOAD,
      ST_WDIV,
      ST_DONE
   } state_type;

   // Length of a month; codes outside January..December count 31 days.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (month) inside
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2:                    len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   // Days in the months before this one in a common year.
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
      logic [DOY_W-1:0] sum;
      case (month) inside
         4'd0, 4'd1: sum = 9'd0;
         4'd2:       sum = 9'd31;
         4'd3:       sum = 9'd59;
         4'd4:       sum = 9'd90;
         4'd5:       sum = 9'd120;
         4'd6:       sum = 9'd151;
         4'd7:       sum = 9'd181;
         4'd8:       sum = 9'd212;
         4'd9:       sum = 9'd243;
         4'd10:      sum = 9'd273;
         4'd11:      sum = 9'd304;
         4'd12:      sum = 9'd334;
         default:    sum = 9'd365;
      endcase
      return sum;
   endfunction

   // Month term of Zeller's congruence, (13 * mm + 8) / 5.
   function automatic logic [ZT_W-1:0] zeller_term(input logic [MONTH_W-1:0] mm);
      logic [ZT_W-1:0] term;
      case (mm)
         4'd0:    term = 6'd1;
         4'd1:    term = 6'd4;
         4'd2:    term = 6'd6;
         4'd3:    term = 6'd9;
         4'd4:    term = 6'd12;
         4'd5:    term = 6'd14;
         4'd6:    term = 6'd17;
         4'd7:    term = 6'd19;
         4'd8:    term = 6'd22;
         4'd9:    term = 6'd25;
         4'd10:   term = 6'd27;
         4'd11:   term = 6'd30;
         4'd12:   term = 6'd32;
         4'd13:   term = 6'd35;
         4'd14:   term = 6'd38;
         default: term = 6'd40;
      endcase
      return term;
   endfunction

endpackage

/* rtl/calendar_date_stepper_top.sv */
// Calendar date stepper: holds a Gregorian date and loads, advances or backs it up.
// Depends on cds_pkg for widths, codes, states and calendar tables.
// Sequence: an item is accepted in idle; year / 100 is formed by reciprocal multiplication,
// quotient then remainder; the date then steps one day per cycle, each year boundary
// crossed repeating the year division; the weekday sum mod 7 is divided the same way.
// The result register loads once the output is free; the next item is taken the cycle
// after the result register loads. Synchronous reset sets the date to 0001-01-01 and
// empties the result register.
module calendar_date_stepper_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cds_pkg::OP_W-1:0]      req_operation,
   input  logic [cds_pkg::YEAR_W-1:0]    req_load_year,
   input  logic [cds_pkg::MONTH_W-1:0]   req_load_month,
   input  logic [cds_pkg::DAY_W-1:0]     req_load_day,
   input  logic [cds_pkg::COUNT_W-1:0]   req_step_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cds_pkg::YEAR_W-1:0]    rsp_year,
   output logic [cds_pkg::MONTH_W-1:0]   rsp_month,
   output logic [cds_pkg::DAY_W-1:0]     rsp_day,
   output logic [cds_pkg::DOY_W-1:0]     rsp_day_in_year,
   output logic [cds_pkg::WDAY_W-1:0]    rsp_weekday,
   output logic                          rsp_range_flag
);
   import cds_pkg::*;

   state_type state_ff, state_in;

   logic [YEAR_W-1:0]    year_ff, year_in;
   logic [MONTH_W-1:0]   month_ff, month_in;
   logic [DAY_W-1:0]     day_ff, day_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 back_ff, back_in;
   logic                 flag_ff, flag_in;
   logic                 leap_ff, leap_in;

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [REM_W-1:0]     rem_ff, rem_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [YEAR_W-1:0]    rsp_year_ff, rsp_year_in;
   logic [MONTH_W-1:0]   rsp_month_ff, rsp_month_in;
   logic [DAY_W-1:0]     rsp_day_ff, rsp_day_in;
   logic [DOY_W-1:0]     rsp_doy_ff, rsp_doy_in;
   logic [WDAY_W-1:0]    rsp_wday_ff, rsp_wday_in;
   logic                 rsp_flag_ff, rsp_flag_in;

   // Sequencer strobes.
   logic req_fire, rsp_free;
   logic start_year_div, year_rem_en, start_week_div, week_rem_en;
   logic step_en, capture_leap, rsp_load;

   // Reciprocal division.
   logic [CENT_PROD_W-1:0] cent_prod;
   logic [CENT_W-1:0]      cent_quo;
   logic [YEAR_W-1:0]      cent_rem;
   logic [WEEK_PROD_W-1:0] week_prod;
   logic [DIV_W-1:0]       week_quo, week_rem;

   // Calendar arithmetic.
   logic               leap_now;
   logic [DAY_W-1:0]   md_cur;
   logic [YEAR_W-1:0]  step_year;
   logic [MONTH_W-1:0] step_month;
   logic [DAY_W-1:0]   step_day;
   logic               step_refuse, step_year_chg;
   logic               early;
   logic [YY_W-1:0]    yy;
   logic [CENT_W-1:0]  cent;
   logic [MONTH_W-1:0] mm;
   logic [DIV_W-1:0]   wsum;
   logic [DOY_W-1:0]   doy;

   assign req_fire = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_YLOAD;
         ST_YLOAD: state_in = ST_YDIV;
         ST_YDIV:  state_in = (count_ff != '0) ? ST_STEP : ST_WLOAD;
         ST_STEP: begin
            if (step_refuse) state_in = ST_WLOAD;
            else if (step_year_chg) state_in = ST_YLOAD;
            else if (count_ff == COUNT_W'(1)) state_in = ST_WLOAD;
         end
         ST_WLOAD: state_in = ST_WDIV;
         ST_WDIV:  state_in = ST_DONE;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------- sequencer outputs ----------------
   always_comb begin
      req_stall      = 1'b1;
      start_year_div = 1'b0;
      year_rem_en    = 1'b0;
      start_week_div = 1'b0;
      week_rem_en    = 1'b0;
      step_en        = 1'b0;
      capture_leap   = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_YLOAD: start_year_div = 1'b1;
         ST_YDIV:  year_rem_en = 1'b1;
         ST_STEP:  step_en = 1'b1;
         ST_WLOAD: begin
            start_week_div = 1'b1;
            capture_leap   = 1'b1;
         end
         ST_WDIV:  week_rem_en = 1'b1;
         ST_DONE:  rsp_load = rsp_free;
         default:  req_stall = 1'b1;
      endcase
   end

   // ---------------- reciprocal division ----------------
   // The quotient is registered first; the remainder follows from it the next cycle.
   assign cent_prod = CENT_PROD_W'(year_ff) * CENT_PROD_W'(CENT_RECIP);
   assign cent_quo  = cent_prod[CENT_SHIFT +: CENT_W];
   assign cent_rem  = year_ff - YEAR_W'(quo_ff[CENT_W-1:0]) * YEAR_W'(DIVISOR_CENTURY);
   assign week_prod = WEEK_PROD_W'(quo_ff) * WEEK_PROD_W'(WEEK_RECIP);
   assign week_quo  = DIV_W'(week_prod[WEEK_PROD_W-1:WEEK_SHIFT]);
   assign week_rem  = quo_ff - week_quo * DIV_W'(DIVISOR_WEEK);

   // While the divider holds year / 100, the leap test reads its quotient and remainder.
   assign leap_now = (year_ff[1:0] == 2'd0) &&
                     ((rem_ff != '0) || (quo_ff[1:0] == 2'd0));
   assign md_cur   = month_len(month_ff, leap_now);

   // ---------------- one day forward or back ----------------
   always_comb begin
      step_refuse = 1'b0;
      step_year   = year_ff;
      step_month  = month_ff;
      step_day    = day_ff;
      if (!back_ff) begin
         if (day_ff < md_cur) begin
            step_day = day_ff + DAY_FIRST;
         end else if (month_ff >= MONTHS) begin
            if (year_ff >= YEAR_MAX) begin
               step_refuse = 1'b1;
            end else begin
               step_year  = year_ff + YEAR_W'(1);
               step_month = MONTH_JAN;
               step_day   = DAY_FIRST;
            end
         end else begin
            step_month = month_ff + MONTH_W'(1);
            step_day   = DAY_FIRST;
         end
      end else begin
         if (day_ff > DAY_FIRST) begin
            step_day = day_ff - DAY_FIRST;
         end else if (month_ff <= MONTH_JAN) begin
            if (year_ff <= YEAR_MIN) begin
               step_refuse = 1'b1;
            end else begin
               // December is never a leap-dependent month.
               step_year  = year_ff - YEAR_W'(1);
               step_month = MONTHS;
               step_day   = month_len(MONTHS, 1'b0);
            end
         end else begin
            step_month = month_ff - MONTH_W'(1);
            step_day   = month_len(month_ff - MONTH_W'(1), leap_now);
         end
      end
   end

   assign step_year_chg = (step_year != year_ff);

   // ---------------- weekday dividend (Zeller, year biased by 400) ----------------
   // January and February count as months 13 and 14 of the year before.
   assign early = (month_ff == MONTH_JAN) || (month_ff == MONTH_FEB);
   assign yy    = YY_W'(year_ff) + WEEK_YEAR_BIAS - YY_W'(early);
   assign cent  = quo_ff[CENT_W-1:0] + ((early && (rem_ff == '0)) ? CENT_W'(3) : CENT_W'(4));
   assign mm    = early ? (month_ff + MONTHS) : month_ff;
   assign wsum  = DIV_W'(yy) + DIV_W'(yy >> 2) - DIV_W'(cent) + DIV_W'(cent >> 2)
                + DIV_W'(zeller_term(mm)) + DIV_W'(day_ff);

   assign doy = DOY_W'(day_ff) + days_before(month_ff)
              + DOY_W'(leap_ff && (month_ff > MONTH_FEB));

   // ---------------- register next values ----------------
   always_comb begin
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      count_in     = count_ff;
      back_in      = back_ff;
      flag_in      = flag_ff;
      leap_in      = leap_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_month_in = rsp_month_ff;
      rsp_day_in   = rsp_day_ff;
      rsp_doy_in   = rsp_doy_ff;
      rsp_wday_in  = rsp_wday_ff;
      rsp_flag_in  = rsp_flag_ff;

      if (req_fire) begin
         if (req_operation == OP_LOAD) begin
            year_in  = req_load_year;
            month_in = req_load_month;
            day_in   = req_load_day;
         end
         count_in = ((req_operation == OP_ADVANCE) || (req_operation == OP_BACK)) ?
                    req_step_count : '0;
         back_in  = (req_operation == OP_BACK);
         flag_in  = 1'b0;
      end

      if (step_en) begin
         year_in  = step_year;
         month_in = step_month;
         day_in   = step_day;
         count_in = count_ff - COUNT_W'(1);
         if (step_refuse) flag_in = 1'b1;
      end

      if (start_year_div) begin
         quo_in = DIV_W'(cent_quo);
      end else if (year_rem_en) begin
         rem_in = cent_rem[REM_W-1:0];
      end else if (start_week_div) begin
         quo_in = wsum;
      end else if (week_rem_en) begin
         rem_in = week_rem[REM_W-1:0];
      end

      if (capture_leap) leap_in = leap_now;

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_year_in  = year_ff;
         rsp_month_in = month_ff;
         rsp_day_in   = day_ff;
         rsp_doy_in   = doy;
         rsp_wday_in  = rem_ff[WDAY_W-1:0];
         rsp_flag_in  = flag_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         year_ff      <= YEAR_MIN;
         month_ff     <= MONTH_JAN;
         day_ff       <= DAY_FIRST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff     <= count_in;
      back_ff      <= back_in;
      flag_ff      <= flag_in;
      leap_ff      <= leap_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_month_ff <= rsp_month_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_doy_ff   <= rsp_doy_in;
      rsp_wday_ff  <= rsp_wday_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_year        = rsp_year_ff;
   assign rsp_month       = rsp_month_ff;
   assign rsp_day         = rsp_day_ff;
   assign rsp_day_in_year = rsp_doy_ff;
   assign rsp_weekday     = rsp_wday_ff;
   assign rsp_range_flag  = rsp_flag_ff;

   // ---------------- assertions ----------------
   // A year crossing must recompute the leap test before the next step.
   a_year_change_reloads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && step_en && step_year_chg) |=> (state_ff == ST_YLOAD))
      else $error("year changed during stepping without a divider reload");

   a_count_decrements: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && !step_refuse) |=> (count_ff == $past(count_ff) - COUNT_W'(1)))
      else $error("step count did not decrement on a taken step");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result register loaded outside the done state");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_wday_ff <= WDAY_W'(6)))
      else $error("weekday remainder out of range");

   a_flag_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flag_ff) |-> ((rsp_year_ff >= YEAR_MAX) || (rsp_year_ff <= YEAR_MIN)))
      else $error("range flag raised away from the year limits");

endmodule
